>>> rtl/ipdc_pkg.sv
// shared types and constants for the image pair difference checker
`timescale 1ns / 1ps

package ipdc_pkg;

  // changed-pixel counter width, limited by the 24-bit result field
  localparam int COUNT_BITS  = 24;
  localparam int FIELD_CNT_W = 24;
  localparam int CNT_W       = (COUNT_BITS < FIELD_CNT_W) ? COUNT_BITS : FIELD_CNT_W;

  // highlight scaling: score times eight, clamped
  localparam int         AMP_SHIFT  = 3;
  localparam int         AMP_W      = 8 + AMP_SHIFT;
  localparam logic [7:0] HILITE_MAX = 8'hFF;

  // queue between classifier and accumulator
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // register port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  typedef enum logic {
    REG_THRESHOLD = 1'b0,
    REG_BUDGET    = 1'b1
  } reg_idx_t;

  // one classified pixel
  typedef struct packed {
    logic [7:0] score;
    logic       changed;
    logic [7:0] highlight;
    logic       last;
  } pix_entry_t;

  // queue status
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

>>> rtl/ipdc_front.sv
// front end: per-pixel difference score, changed flag and highlight
`timescale 1ns / 1ps

module ipdc_front (
  input  logic [7:0]          in_actual_red,
  input  logic [7:0]          in_actual_green,
  input  logic [7:0]          in_actual_blue,
  input  logic [7:0]          in_reference_red,
  input  logic [7:0]          in_reference_green,
  input  logic [7:0]          in_reference_blue,
  input  logic                in_final_pixel,
  output ipdc_pkg::pix_entry_t entry
);
  import ipdc_pkg::*;

  logic [7:0]       diff_r;
  logic [7:0]       diff_g;
  logic [7:0]       diff_b;
  logic [7:0]       max_rg;
  logic [7:0]       score;
  logic [AMP_W-1:0] amp;

  // absolute channel differences
  assign diff_r = (in_actual_red > in_reference_red) ?
                  in_actual_red - in_reference_red : in_reference_red - in_actual_red;
  assign diff_g = (in_actual_green > in_reference_green) ?
                  in_actual_green - in_reference_green : in_reference_green - in_actual_green;
  assign diff_b = (in_actual_blue > in_reference_blue) ?
                  in_actual_blue - in_reference_blue : in_reference_blue - in_actual_blue;

  // largest difference
  assign max_rg = (diff_g > diff_r) ? diff_g : diff_r;
  assign score  = (diff_b > max_rg) ? diff_b : max_rg;

  // amplified highlight with clamp
  assign amp = AMP_W'(score) << AMP_SHIFT;

  always_comb begin
    entry.score     = score;
    entry.changed   = (score != 8'd0);
    entry.highlight = (amp > AMP_W'(HILITE_MAX)) ? HILITE_MAX : amp[7:0];
    entry.last      = in_final_pixel;
  end

endmodule

>>> rtl/ipdc_queue.sv
// short queue of classified pixels between front and back
`timescale 1ns / 1ps

module ipdc_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  ipdc_pkg::pix_entry_t wdata,
  input  logic                 pop,
  output ipdc_pkg::pix_entry_t rdata,
  output ipdc_pkg::q_status_t  status
);
  import ipdc_pkg::*;

  pix_entry_t         slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               do_push;
  logic               do_pop;

  assign status.full  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign status.empty = (cnt_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign rdata        = slot_r[rd_ptr_r];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

>>> rtl/ipdc_back.sv
// back end: image accumulators, verdict and result register
`timescale 1ns / 1ps

module ipdc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [7:0]           threshold,
  input  logic [23:0]          budget,
  input  ipdc_pkg::pix_entry_t entry,
  input  logic                 entry_avail,
  output logic                 entry_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_pixel_score,
  output logic                 out_pixel_changed,
  output logic [7:0]           out_highlight_red,
  output logic                 out_image_done,
  output logic                 out_image_pass,
  output logic [7:0]           out_peak_score,
  output logic [23:0]          out_changed_count,
  output logic [31:0]          out_score_sum
);
  import ipdc_pkg::*;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  logic [7:0]       peak_r, peak_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]      sum_r, sum_nxt;
  logic [32:0]      sum_add;
  logic             valid_r, valid_nxt;
  logic             pass;

  logic [7:0]  score_r;
  logic        changed_r;
  logic [7:0]  highlight_r;
  logic        done_r;
  logic        pass_r;
  logic [7:0]  peak_out_r;
  logic [23:0] cnt_out_r;
  logic [31:0] sum_out_r;

  // take an entry when the result register is free or being drained
  assign entry_pop = entry_avail && (!valid_r || !out_stall);

  // running totals including this pixel
  assign sum_add  = {1'b0, sum_r} + 33'(entry.score);
  assign peak_nxt = (entry.score > peak_r) ? entry.score : peak_r;
  assign cnt_nxt  = (entry.changed && cnt_r != CNT_MAX) ? cnt_r + 1'b1 : cnt_r;
  assign sum_nxt  = sum_add[32] ? '1 : sum_add[31:0];
  assign pass     = (peak_nxt <= threshold) && (24'(cnt_nxt) <= budget);

  assign valid_nxt = entry_pop || (valid_r && out_stall);

  // accumulators and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r  <= '0;
      cnt_r   <= '0;
      sum_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (entry_pop) begin
        if (entry.last) begin
          peak_r <= '0;
          cnt_r  <= '0;
          sum_r  <= '0;
        end else begin
          peak_r <= peak_nxt;
          cnt_r  <= cnt_nxt;
          sum_r  <= sum_nxt;
        end
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (entry_pop) begin
      score_r     <= entry.score;
      changed_r   <= entry.changed;
      highlight_r <= entry.highlight;
      done_r      <= entry.last;
      pass_r      <= entry.last && pass;
      peak_out_r  <= entry.last ? peak_nxt : 8'd0;
      cnt_out_r   <= entry.last ? 24'(cnt_nxt) : 24'd0;
      sum_out_r   <= entry.last ? sum_nxt : 32'd0;
    end
  end

  assign out_valid         = valid_r;
  assign out_pixel_score   = score_r;
  assign out_pixel_changed = changed_r;
  assign out_highlight_red = highlight_r;
  assign out_image_done    = done_r;
  assign out_image_pass    = pass_r;
  assign out_peak_score    = peak_out_r;
  assign out_changed_count = cnt_out_r;
  assign out_score_sum     = sum_out_r;

endmodule

>>> rtl/image_pair_difference_checker.sv
// top level: register port, classifier, queue and accumulator
//
//   channel   direction  handshake        payload
//   in_*      input      valid / stall    actual and reference rgb, final flag
//   out_*     output     valid / stall    score, flags, highlight, image totals
//   apb       input      psel / penable   threshold (addr 0), budget (addr 4)
//
// one transaction per cycle sustained while out_stall is low; each result is registered
// in a queue slot and then in the result register (classify into queue, then accumulate)
// a four-entry queue absorbs output stall; in_stall rises only when it is full
// rst_n is synchronous; it clears queue, accumulators, valid and registers
// totals include the final pixel and clear after it
`timescale 1ns / 1ps

module image_pair_difference_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ipdc_pkg::ADDR_W-1:0]   paddr,
  input  logic [ipdc_pkg::DATA_W-1:0]   pwdata,
  output logic [ipdc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  // pixel input
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_actual_red,
  input  logic [7:0]                    in_actual_green,
  input  logic [7:0]                    in_actual_blue,
  input  logic [7:0]                    in_reference_red,
  input  logic [7:0]                    in_reference_green,
  input  logic [7:0]                    in_reference_blue,
  input  logic                          in_final_pixel,
  // result output
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_pixel_score,
  output logic                          out_pixel_changed,
  output logic [7:0]                    out_highlight_red,
  output logic                          out_image_done,
  output logic                          out_image_pass,
  output logic [7:0]                    out_peak_score,
  output logic [23:0]                   out_changed_count,
  output logic [31:0]                   out_score_sum
);
  import ipdc_pkg::*;

  logic [7:0]  threshold_r;
  logic [23:0] budget_r;
  logic        cfg_wr;
  reg_idx_t    reg_idx;

  pix_entry_t  front_entry;
  pix_entry_t  q_entry;
  q_status_t   q_stat;
  logic        q_push;
  logic        q_pop;

  // register port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= '0;
      budget_r    <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_THRESHOLD: threshold_r <= pwdata[7:0];
        REG_BUDGET:    budget_r    <= pwdata[23:0];
        default:       threshold_r <= threshold_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_THRESHOLD: prdata = DATA_W'(threshold_r);
      REG_BUDGET:    prdata = DATA_W'(budget_r);
      default:       prdata = '0;
    endcase
  end

  // classify incoming pixels
  ipdc_front u_front (
    .in_actual_red      (in_actual_red),
    .in_actual_green    (in_actual_green),
    .in_actual_blue     (in_actual_blue),
    .in_reference_red   (in_reference_red),
    .in_reference_green (in_reference_green),
    .in_reference_blue  (in_reference_blue),
    .in_final_pixel     (in_final_pixel),
    .entry              (front_entry)
  );

  assign in_stall = q_stat.full;
  assign q_push   = in_valid && !in_stall;

  // decoupling queue
  ipdc_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (front_entry),
    .pop    (q_pop),
    .rdata  (q_entry),
    .status (q_stat)
  );

  // accumulate and deliver
  ipdc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .threshold         (threshold_r),
    .budget            (budget_r),
    .entry             (q_entry),
    .entry_avail       (!q_stat.empty),
    .entry_pop         (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pixel_score   (out_pixel_score),
    .out_pixel_changed (out_pixel_changed),
    .out_highlight_red (out_highlight_red),
    .out_image_done    (out_image_done),
    .out_image_pass    (out_image_pass),
    .out_peak_score    (out_peak_score),
    .out_changed_count (out_changed_count),
    .out_score_sum     (out_score_sum)
  );

`ifndef SYNTHESIS
  // queue never reports full and empty together
  a_q_status: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue full and empty at once");

  // totals only on the last pixel of an image
  a_totals_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_image_done) |->
      (!out_image_pass && out_peak_score == 8'd0 &&
       out_changed_count == 24'd0 && out_score_sum == 32'd0))
    else $error("image totals on a non-final transaction");

  // changed flag follows the score
  a_changed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pixel_changed == (out_pixel_score != 8'd0)))
    else $error("changed flag disagrees with score");

  // peak of a final pixel covers that pixel
  a_peak: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_image_done) |-> (out_peak_score >= out_pixel_score))
    else $error("peak below final pixel score");

  // nothing is presented right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");
`endif

endmodule

>>> tb/sv/difference_result_checker.sv
// checker: predicts pixel scores and image totals and compares each result transaction
`timescale 1ns / 1ps

module difference_result_checker
  import ipdc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic [DATA_W-1:0] prdata,
  // pixel input
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [7:0]        in_actual_red,
  input  logic [7:0]        in_actual_green,
  input  logic [7:0]        in_actual_blue,
  input  logic [7:0]        in_reference_red,
  input  logic [7:0]        in_reference_green,
  input  logic [7:0]        in_reference_blue,
  input  logic              in_final_pixel,
  // result output
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [7:0]        out_pixel_score,
  input  logic              out_pixel_changed,
  input  logic [7:0]        out_highlight_red,
  input  logic              out_image_done,
  input  logic              out_image_pass,
  input  logic [7:0]        out_peak_score,
  input  logic [23:0]       out_changed_count,
  input  logic [31:0]       out_score_sum,
  // status for the stimulus side
  output int unsigned       mismatch_count,
  output int unsigned       results_pending
);

  typedef struct {
    logic [7:0]  pixel_score;
    logic        pixel_changed;
    logic [7:0]  highlight_red;
    logic        image_done;
    logic        image_pass;
    logic [7:0]  peak_score;
    logic [23:0] changed_count;
    logic [31:0] score_sum;
  } pixel_result_t;

  localparam logic [CNT_W-1:0] COUNT_CEILING = '1;
  localparam logic [31:0]      SUM_CEILING   = '1;

  // shadow registers and image accumulators
  logic [7:0]       threshold_reg;
  logic [23:0]      budget_reg;
  logic [7:0]       peak_acc;
  logic [CNT_W-1:0] changed_acc;
  logic [31:0]      sum_acc;
  pixel_result_t    scored_pixels[$];

  function automatic logic [7:0] channel_delta(logic [7:0] a, logic [7:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // score one pixel pair and fold it into the running image totals
  function automatic pixel_result_t score_pixel(
    logic [7:0] ar, logic [7:0] ag, logic [7:0] ab,
    logic [7:0] rr, logic [7:0] rg, logic [7:0] rb, logic last);
    pixel_result_t   r;
    logic [7:0]      s;
    logic [AMP_W-1:0] amp;
    s = channel_delta(ar, rr);
    if (channel_delta(ag, rg) > s) s = channel_delta(ag, rg);
    if (channel_delta(ab, rb) > s) s = channel_delta(ab, rb);
    amp = AMP_W'(s) << AMP_SHIFT;
    r.pixel_score   = s;
    r.pixel_changed = (s != 8'd0);
    r.highlight_red = (amp > AMP_W'(HILITE_MAX)) ? HILITE_MAX : amp[7:0];
    r.image_done    = last;
    r.image_pass    = 1'b0;
    r.peak_score    = '0;
    r.changed_count = '0;
    r.score_sum     = '0;
    if (s > peak_acc) peak_acc = s;
    if (s != 8'd0 && changed_acc != COUNT_CEILING) changed_acc = changed_acc + 1'b1;
    if (sum_acc > SUM_CEILING - 32'(s)) sum_acc = SUM_CEILING;
    else sum_acc = sum_acc + 32'(s);
    // totals include this pixel, then the image starts over
    if (last) begin
      r.image_pass    = (peak_acc <= threshold_reg) && (changed_acc <= budget_reg);
      r.peak_score    = peak_acc;
      r.changed_count = 24'(changed_acc);
      r.score_sum     = sum_acc;
      peak_acc        = '0;
      changed_acc     = '0;
      sum_acc         = '0;
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    pixel_result_t want;
    if (!rst_n) begin
      threshold_reg  = '0;
      budget_reg     = '0;
      peak_acc       = '0;
      changed_acc    = '0;
      sum_acc        = '0;
      mismatch_count = 0;
      scored_pixels.delete();
    end else begin
      // register transactions: track writes, check reads
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (reg_idx_t'(paddr[ADDR_W-1:2]))
            REG_THRESHOLD: threshold_reg = pwdata[7:0];
            REG_BUDGET:    budget_reg    = pwdata[23:0];
          endcase
        end else begin
          case (reg_idx_t'(paddr[ADDR_W-1:2]))
            REG_THRESHOLD: check_field("prdata threshold", 32'(threshold_reg), prdata);
            REG_BUDGET:    check_field("prdata budget", 32'(budget_reg), prdata);
          endcase
        end
      end
      // result transaction against the oldest prediction
      if (out_valid && !out_stall) begin
        if (scored_pixels.size() == 0) begin
          $error("result transaction with no pixel pending");
          mismatch_count++;
        end else begin
          want = scored_pixels.pop_front();
          check_field("pixel_score", 32'(want.pixel_score), 32'(out_pixel_score));
          check_field("pixel_changed", 32'(want.pixel_changed), 32'(out_pixel_changed));
          check_field("highlight_red", 32'(want.highlight_red), 32'(out_highlight_red));
          check_field("image_done", 32'(want.image_done), 32'(out_image_done));
          check_field("image_pass", 32'(want.image_pass), 32'(out_image_pass));
          check_field("peak_score", 32'(want.peak_score), 32'(out_peak_score));
          check_field("changed_count", 32'(want.changed_count), 32'(out_changed_count));
          check_field("score_sum", want.score_sum, out_score_sum);
        end
      end
      // pixel transaction
      if (in_valid && !in_stall)
        scored_pixels.push_back(score_pixel(in_actual_red, in_actual_green, in_actual_blue,
                                            in_reference_red, in_reference_green,
                                            in_reference_blue, in_final_pixel));
    end
    results_pending = scored_pixels.size();
  end

endmodule

>>> tb/sv/tb_image_pair_difference_checker.sv
// testbench top: clock, reset, register setup, pixel stimulus and verdict
`timescale 1ns / 1ps

module tb_image_pair_difference_checker;
  import ipdc_pkg::*;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid;
  logic              in_stall;
  logic [7:0]        in_actual_red;
  logic [7:0]        in_actual_green;
  logic [7:0]        in_actual_blue;
  logic [7:0]        in_reference_red;
  logic [7:0]        in_reference_green;
  logic [7:0]        in_reference_blue;
  logic              in_final_pixel;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [7:0]        out_pixel_score;
  logic              out_pixel_changed;
  logic [7:0]        out_highlight_red;
  logic              out_image_done;
  logic              out_image_pass;
  logic [7:0]        out_peak_score;
  logic [23:0]       out_changed_count;
  logic [31:0]       out_score_sum;
  int unsigned       mismatch_count;
  int unsigned       results_pending;

  // idle controls, set per image
  int unsigned gap_pct    = 0;
  int unsigned stall_pct  = 0;
  int unsigned stall_left = 0;
  int unsigned pixels_sent = 0;

  image_pair_difference_checker i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_actual_red      (in_actual_red),
    .in_actual_green    (in_actual_green),
    .in_actual_blue     (in_actual_blue),
    .in_reference_red   (in_reference_red),
    .in_reference_green (in_reference_green),
    .in_reference_blue  (in_reference_blue),
    .in_final_pixel     (in_final_pixel),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_pixel_score    (out_pixel_score),
    .out_pixel_changed  (out_pixel_changed),
    .out_highlight_red  (out_highlight_red),
    .out_image_done     (out_image_done),
    .out_image_pass     (out_image_pass),
    .out_peak_score     (out_peak_score),
    .out_changed_count  (out_changed_count),
    .out_score_sum      (out_score_sum)
  );

  difference_result_checker i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .pready             (pready),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_actual_red      (in_actual_red),
    .in_actual_green    (in_actual_green),
    .in_actual_blue     (in_actual_blue),
    .in_reference_red   (in_reference_red),
    .in_reference_green (in_reference_green),
    .in_reference_blue  (in_reference_blue),
    .in_final_pixel     (in_final_pixel),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_pixel_score    (out_pixel_score),
    .out_pixel_changed  (out_pixel_changed),
    .out_highlight_red  (out_highlight_red),
    .out_image_done     (out_image_done),
    .out_image_pass     (out_image_pass),
    .out_peak_score     (out_peak_score),
    .out_changed_count  (out_changed_count),
    .out_score_sum      (out_score_sum),
    .mismatch_count     (mismatch_count),
    .results_pending    (results_pending)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // result side back-pressure in bursts of random length
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(99) < stall_pct) begin
      stall_left = $urandom_range(9);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // register write: setup then access, entered and left at a falling edge
  task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = '0;
    paddr[ADDR_W-1:2] = idx;
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // register read, data checked by the checker in the access phase
  task automatic read_reg(reg_idx_t idx);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    paddr[ADDR_W-1:2] = idx;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // one pixel transaction; valid stays high on return for back-to-back pixels
  task automatic send_pixel(logic [7:0] ar, logic [7:0] ag, logic [7:0] ab,
                            logic [7:0] rr, logic [7:0] rg, logic [7:0] rb, logic last);
    int unsigned gap;
    gap = ($urandom_range(99) < gap_pct) ? $urandom_range(1, 10) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_actual_red      = ar;
    in_actual_green    = ag;
    in_actual_blue     = ab;
    in_reference_red   = rr;
    in_reference_green = rg;
    in_reference_blue  = rb;
    in_final_pixel     = last;
    in_valid           = 1'b1;
    do @(posedge clk); while (in_stall);
    pixels_sent++;
    @(negedge clk);
  endtask

  // one image of random pixels: identical, near-identical or unrelated pairs;
  // a broken image carries random end markers instead
  task automatic send_image(int unsigned len, bit broken);
    logic [7:0] cap_px [3];
    logic [7:0] ref_px [3];
    int         kind;
    int         shifted;
    for (int i = 0; i < len; i++) begin
      kind = $urandom_range(9);
      for (int c = 0; c < 3; c++) begin
        cap_px[c] = 8'($urandom);
        if (kind < 2) begin
          ref_px[c] = cap_px[c];
        end else if (kind < 6) begin
          shifted = int'(cap_px[c]) + int'($urandom_range(16)) - 8;
          if (shifted < 0) shifted = 0;
          if (shifted > 255) shifted = 255;
          ref_px[c] = shifted[7:0];
        end else begin
          ref_px[c] = 8'($urandom);
        end
      end
      send_pixel(cap_px[0], cap_px[1], cap_px[2], ref_px[0], ref_px[1], ref_px[2],
                 broken ? 1'($urandom_range(1)) : (i == len - 1));
    end
  endtask

  // wait for the block to drain, program both registers, then stream images
  task automatic run_phase(logic [DATA_W-1:0] thr_word, logic [DATA_W-1:0] budget_word,
                           int unsigned count, bit quiet);
    int unsigned target;
    int unsigned len;
    // no new stall bursts once the full-rate stretch is coming
    if (quiet) begin
      gap_pct   = 0;
      stall_pct = 0;
    end
    while (results_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    write_reg(REG_THRESHOLD, thr_word);
    write_reg(REG_BUDGET, budget_word);
    read_reg(REG_THRESHOLD);
    read_reg(REG_BUDGET);
    target = pixels_sent + count;
    while (pixels_sent < target) begin
      if (quiet) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        case ($urandom_range(2))
          0: gap_pct = 0;
          1: gap_pct = 10;
          default: gap_pct = 40;
        endcase
        case ($urandom_range(2))
          0: stall_pct = 0;
          1: stall_pct = 10;
          default: stall_pct = 40;
        endcase
      end
      len = ($urandom_range(9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
      send_image(len, !quiet && ($urandom_range(9) == 0));
    end
    in_valid = 1'b0;
  endtask

  initial begin
    rst_n              = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    in_valid           = 1'b0;
    in_actual_red      = '0;
    in_actual_green    = '0;
    in_actual_blue     = '0;
    in_reference_red   = '0;
    in_reference_green = '0;
    in_reference_blue  = '0;
    in_final_pixel     = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset values, then directed pixels with threshold and budget at zero
    read_reg(REG_THRESHOLD);
    read_reg(REG_BUDGET);
    // lone final pixel with nothing before it
    send_pixel(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
    // full-scale differences both ways, highlight clamp
    send_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b0);
    send_pixel(8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    // highlight just below and just above the clamp, red then green leading
    send_pixel(8'd31, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    send_pixel(8'h00, 8'h00, 8'h00, 8'h00, 8'd32, 8'h00, 1'b0);
    // smallest nonzero score on blue, ending a failing image
    send_pixel(8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 1'b1);
    // clean single-pixel image
    send_pixel(8'hAA, 8'h55, 8'hAA, 8'hAA, 8'h55, 8'hAA, 1'b1);
    // equal differences on two channels
    send_pixel(8'h55, 8'hAA, 8'h55, 8'h54, 8'hAA, 8'h56, 1'b0);
    send_pixel(8'd128, 8'd128, 8'd128, 8'd127, 8'd129, 8'd128, 1'b1);
    in_valid = 1'b0;

    // widest limits, upper data bits set
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 100, 1'b0);
    // tight limits near typical scores, junk in unused bits
    run_phase(($urandom & 32'hFFFF_FF00) | $urandom_range(16),
              ($urandom & 32'hFF00_0000) | $urandom_range(20), 100, 1'b0);
    // zero limits: only identical images pass
    run_phase(32'h0, 32'h0, 100, 1'b0);
    // anything goes
    run_phase($urandom, $urandom, 100, 1'b0);
    // closing stretch at full rate
    run_phase($urandom_range(4, 12), $urandom_range(8), 150, 1'b1);

    while (results_pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
